// ----- hw/rtl/lslf_pkg.sv -----
`timescale 1ns / 1ps
package lslf_pkg;

   localparam int MaxSamplesDefault = 256;
   localparam logic [23:0] FieldGainReset = 24'd595480;

   typedef struct packed {
      logic [15:0] coil_current;
      logic [15:0] hall_voltage;
      logic        last_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] intercept;
      logic [31:0]        mean_field;
      logic [31:0]        mean_voltage;
      logic               degenerate;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_F0,
      ST_PRD_NXX,
      ST_PRD_SXSX,
      ST_PRD_P,
      ST_PRD_Q,
      ST_PRD_A,
      ST_PRD_B,
      ST_F2,
      ST_F3,
      ST_DIV_MX,
      ST_DIV_MY,
      ST_DIV_SL,
      ST_DIV_IC,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic prd_start;
      logic [2:0] prd_sel;
      logic f2;
      logic f3;
      logic div_start;
      logic [1:0] div_sel;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic prd_done;
      logic div_done;
      logic degen;
   } stat_type;

   localparam logic [1:0] DIV_MX = 2'd0;
   localparam logic [1:0] DIV_MY = 2'd1;
   localparam logic [1:0] DIV_SL = 2'd2;
   localparam logic [1:0] DIV_IC = 2'd3;

   localparam logic [2:0] PRD_NXX  = 3'd0;
   localparam logic [2:0] PRD_SXSX = 3'd1;
   localparam logic [2:0] PRD_P    = 3'd2;
   localparam logic [2:0] PRD_Q    = 3'd3;
   localparam logic [2:0] PRD_A    = 3'd4;
   localparam logic [2:0] PRD_B    = 3'd5;

endpackage

// ----- hw/rtl/least_squares_line_fit.sv -----
`timescale 1ns / 1ps
// Least-squares line fit of Hall voltage against coil field.
// Request channel: drive req_payload and pulse start while busy is low; the
// request is taken on that edge. An ordinary sample keeps busy high through
// the field multiply and accumulate states; no new request is taken before it falls.
// A sample with last_sample set also runs the fit: a start state, six wide
// products on a shared 32x32 multiplier, two compare states, then a shared
// 128-step restoring divider runs once each for mean field, mean voltage,
// slope and intercept; a degenerate fit skips the slope and intercept
// divisions. Busy falls the cycle after the result shows.
// The result shows on rsp_payload for one cycle with rsp_strobe high; the
// receiver cannot stall it. Sums then clear for the next data set.
// csr_valid/csr_ready writes field_gain; ready is always high.
// Reset clears the sums and sets field_gain to its default.
module least_squares_line_fit #(
   parameter int MAX_SAMPLES = lslf_pkg::MaxSamplesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lslf_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output lslf_pkg::rsp_type rsp_payload,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [23:0]       csr_data
);
   logic [23:0] gain_ff;
   lslf_pkg::cmd_type  cmd;
   lslf_pkg::stat_type stat;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) gain_ff <= lslf_pkg::FieldGainReset;
      else if (csr_valid) gain_ff <= csr_data;
   end

   lslf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat),
      .cmd(cmd), .busy(busy), .strobe(rsp_strobe)
   );

   lslf_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock(clock), .reset(reset), .gain(gain_ff), .req(req_payload),
      .cmd(cmd), .stat(stat), .rsp(rsp_payload)
   );

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy) else $error("strobe outside busy");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double strobe");
   a_degen_slope: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.degenerate) |-> (rsp_payload.slope == 0))
      else $error("degenerate slope nonzero");
endmodule

// ----- hw/rtl/lslf_div.sv -----
`timescale 1ns / 1ps
module lslf_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] num,
   input  logic [127:0] den,
   output logic         done,
   output logic [127:0] quo
);
   logic [127:0] rem_ff, rem_in, q_ff, q_in, d_ff, d_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in, done_ff, done_in;
   logic [128:0] sh;

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      sh      = {rem_ff, q_ff[127]};
      if (start) begin
         rem_in = '0;
         q_in   = num;
         d_in   = den;
         cnt_in = 8'd128;
         run_in = 1'b1;
      end else if (run_ff) begin
         q_in = {q_ff[126:0], 1'b0};
         if (sh >= {1'b0, d_ff}) begin
            rem_in   = 128'(sh - {1'b0, d_ff});
            q_in[0]  = 1'b1;
         end else begin
            rem_in = sh[127:0];
         end
         cnt_in = cnt_ff - 8'd1;
         if (cnt_ff == 8'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quo  = q_ff;
endmodule

// ----- hw/rtl/lslf_datapath.sv -----
`timescale 1ns / 1ps
module lslf_datapath #(
   parameter int MAX_SAMPLES = lslf_pkg::MaxSamplesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [23:0]       gain,
   input  lslf_pkg::req_type req,
   input  lslf_pkg::cmd_type cmd,
   output lslf_pkg::stat_type stat,
   output lslf_pkg::rsp_type rsp
);
   localparam int CW = $clog2(MAX_SAMPLES + 1);

   logic [15:0]  cur_ff, volt_ff;
   logic         last_ff;
   logic [27:0]  x_ff;
   logic [CW-1:0] n_ff;
   logic [39:0]  sx_ff;
   logic [63:0]  sxx_ff, sxy_ff;
   logic [23:0]  sy_ff;
   logic [127:0] nxx_ff, sxsx_ff, a_ff, b_ff;
   logic [63:0]  p_ff, q_ff;
   logic [127:0] den_ff, snum_ff, inum_ff;
   logic         sneg_ff, ineg_ff, degen_ff;
   logic [127:0] num, dv, quo;
   logic         dstart, ddone;
   logic [31:0]  mx_ff, my_ff, sl_ff, ic_ff;
   logic [1:0]   sel_ff;
   logic [8:0]   nn;
   logic [27:0]  xw;
   logic [63:0]  opa, opb, ma_ff, mb_ff;
   logic [127:0] macc_ff, mpp_sh;
   logic [2:0]   mcnt_ff, psel_ff;
   logic         mdone_ff;
   logic [31:0]  mpa, mpb;
   logic [63:0]  mpp;

   assign nn = 9'(n_ff);
   assign xw = 28'(({24'd0, cur_ff} * {16'd0, gain}) >> 12);

   function automatic logic [31:0] sat(input logic [127:0] q, input logic neg);
      if (!neg) sat = (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      else sat = (q > 128'h80000000) ? 32'h80000000 : 32'(0 - q[31:0]);
   endfunction

   always_comb begin
      num = '0;
      dv  = 128'd1;
      case (cmd.div_sel)
         lslf_pkg::DIV_MX: begin
            num = 128'({88'd0, sx_ff} + 128'(nn) * 128'd128);
            dv  = 128'(nn) * 128'd256;
         end
         lslf_pkg::DIV_MY: begin
            num = 128'({104'd0, sy_ff} * 128'd512 + 128'(nn));
            dv  = 128'(nn) * 128'd2;
         end
         lslf_pkg::DIV_SL: begin
            num = 128'({snum_ff[126:0], 1'b0} + den_ff);
            dv  = {den_ff[126:0], 1'b0};
         end
         default: begin
            num = 128'({inum_ff[126:0], 1'b0} + den_ff);
            dv  = {den_ff[126:0], 1'b0};
         end
      endcase
   end
   assign dstart = cmd.div_start;

   lslf_div u_div (
      .clock(clock), .reset(reset), .start(dstart),
      .num(num), .den(dv), .done(ddone), .quo(quo)
   );

   always_comb begin
      opa = {24'd0, sx_ff};
      opb = sxy_ff;
      case (cmd.prd_sel)
         lslf_pkg::PRD_NXX: begin
            opa = 64'(nn);
            opb = sxx_ff;
         end
         lslf_pkg::PRD_SXSX: begin
            opa = {24'd0, sx_ff};
            opb = {24'd0, sx_ff};
         end
         lslf_pkg::PRD_P: begin
            opa = 64'(nn);
            opb = sxy_ff;
         end
         lslf_pkg::PRD_Q: begin
            opa = {24'd0, sx_ff};
            opb = {40'd0, sy_ff};
         end
         lslf_pkg::PRD_A: begin
            opa = sxx_ff;
            opb = {40'd0, sy_ff};
         end
         default: begin
            opa = {24'd0, sx_ff};
            opb = sxy_ff;
         end
      endcase
   end

   // one 32x32 partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi
   assign mpa = (mcnt_ff inside {3'd1, 3'd2}) ? ma_ff[63:32] : ma_ff[31:0];
   assign mpb = mcnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign mpp = {32'd0, mpa} * {32'd0, mpb};

   always_comb begin
      case (mcnt_ff)
         3'd4:    mpp_sh = {64'd0, mpp};
         3'd1:    mpp_sh = {mpp, 64'd0};
         default: mpp_sh = {32'd0, mpp, 32'd0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff  <= '0;
         mdone_ff <= 1'b0;
      end else if (cmd.prd_start) begin
         mcnt_ff  <= 3'd4;
         mdone_ff <= 1'b0;
      end else if (mcnt_ff != 3'd0) begin
         mcnt_ff  <= mcnt_ff - 3'd1;
         mdone_ff <= (mcnt_ff == 3'd1);
      end else begin
         mdone_ff <= 1'b0;
      end
      if (cmd.prd_start) begin
         ma_ff   <= opa;
         mb_ff   <= opb;
         macc_ff <= '0;
         psel_ff <= cmd.prd_sel;
      end else if (mcnt_ff != 3'd0) begin
         macc_ff <= macc_ff + mpp_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_ff  <= req.coil_current;
         volt_ff <= req.hall_voltage;
         last_ff <= req.last_sample;
      end
      if (cmd.mul) begin
         x_ff  <= xw;
      end
      if (mdone_ff) begin
         case (psel_ff)
            lslf_pkg::PRD_NXX:  nxx_ff  <= macc_ff;
            lslf_pkg::PRD_SXSX: sxsx_ff <= macc_ff;
            lslf_pkg::PRD_P:    p_ff    <= macc_ff[63:0];
            lslf_pkg::PRD_Q:    q_ff    <= macc_ff[63:0];
            lslf_pkg::PRD_A:    a_ff    <= macc_ff;
            default:            b_ff    <= macc_ff;
         endcase
      end
      if (cmd.f2) begin
         degen_ff <= nxx_ff <= sxsx_ff;
         den_ff   <= nxx_ff - sxsx_ff;
         sneg_ff  <= p_ff < q_ff;
         snum_ff  <= (p_ff < q_ff) ? {32'd0, q_ff - p_ff, 32'd0}
                                  : {32'd0, p_ff - q_ff, 32'd0};
      end
      if (cmd.f3) begin
         ineg_ff <= a_ff < b_ff;
         inum_ff <= (a_ff < b_ff) ? (b_ff - a_ff) << 8 : (a_ff - b_ff) << 8;
      end
      if (cmd.div_start) sel_ff <= cmd.div_sel;
      if (ddone) begin
         case (sel_ff)
            lslf_pkg::DIV_MX: mx_ff <= quo[31:0];
            lslf_pkg::DIV_MY: my_ff <= quo[31:0];
            lslf_pkg::DIV_SL: sl_ff <= sat(quo, sneg_ff);
            default:          ic_ff <= sat(quo, ineg_ff);
         endcase
      end
      if (reset || cmd.emit) begin
         n_ff   <= '0;
         sx_ff  <= '0;
         sxx_ff <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
      end else if (cmd.acc && (32'(n_ff) < MAX_SAMPLES)) begin
         n_ff   <= n_ff + CW'(1);
         sx_ff  <= sx_ff + {12'd0, x_ff};
         sxx_ff <= sxx_ff + 64'(x_ff * x_ff);
         sy_ff  <= sy_ff + {8'd0, volt_ff};
         sxy_ff <= sxy_ff + 64'(x_ff * volt_ff);
      end
   end

   assign stat.last     = last_ff;
   assign stat.prd_done = mdone_ff;
   assign stat.div_done = ddone;
   assign stat.degen    = degen_ff;

   assign rsp.slope        = degen_ff ? 32'sd0 : sl_ff;
   assign rsp.intercept    = degen_ff ? my_ff : ic_ff;
   assign rsp.mean_field   = mx_ff;
   assign rsp.mean_voltage = my_ff;
   assign rsp.degenerate   = degen_ff;
endmodule

// ----- hw/rtl/lslf_ctrl.sv -----
`timescale 1ns / 1ps
module lslf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  lslf_pkg::stat_type stat,
   output lslf_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               strobe
);
   lslf_pkg::state_type st_ff, st_in;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         lslf_pkg::ST_IDLE:   if (start) st_in = lslf_pkg::ST_MUL;
         lslf_pkg::ST_MUL:    st_in = lslf_pkg::ST_ACC;
         lslf_pkg::ST_ACC:    st_in = stat.last ? lslf_pkg::ST_F0 : lslf_pkg::ST_IDLE;
         lslf_pkg::ST_F0:     st_in = lslf_pkg::ST_PRD_NXX;
         lslf_pkg::ST_PRD_NXX:  if (stat.prd_done) st_in = lslf_pkg::ST_PRD_SXSX;
         lslf_pkg::ST_PRD_SXSX: if (stat.prd_done) st_in = lslf_pkg::ST_PRD_P;
         lslf_pkg::ST_PRD_P:    if (stat.prd_done) st_in = lslf_pkg::ST_PRD_Q;
         lslf_pkg::ST_PRD_Q:    if (stat.prd_done) st_in = lslf_pkg::ST_PRD_A;
         lslf_pkg::ST_PRD_A:    if (stat.prd_done) st_in = lslf_pkg::ST_PRD_B;
         lslf_pkg::ST_PRD_B:    if (stat.prd_done) st_in = lslf_pkg::ST_F2;
         lslf_pkg::ST_F2:     st_in = lslf_pkg::ST_F3;
         lslf_pkg::ST_F3:     st_in = lslf_pkg::ST_DIV_MX;
         lslf_pkg::ST_DIV_MX: if (stat.div_done) st_in = lslf_pkg::ST_DIV_MY;
         lslf_pkg::ST_DIV_MY: begin
            if (stat.div_done)
               st_in = stat.degen ? lslf_pkg::ST_EMIT : lslf_pkg::ST_DIV_SL;
         end
         lslf_pkg::ST_DIV_SL: if (stat.div_done) st_in = lslf_pkg::ST_DIV_IC;
         lslf_pkg::ST_DIV_IC: if (stat.div_done) st_in = lslf_pkg::ST_EMIT;
         lslf_pkg::ST_EMIT:   st_in = lslf_pkg::ST_IDLE;
         default:             st_in = lslf_pkg::ST_IDLE;
      endcase
   end

   logic div_idle;
   assign div_idle = 1'b0;

   always_comb begin
      cmd           = '0;
      busy          = st_ff != lslf_pkg::ST_IDLE;
      strobe        = 1'b0;
      cmd.load      = (st_ff == lslf_pkg::ST_IDLE) && start;
      cmd.div_sel   = lslf_pkg::DIV_MX;
      cmd.prd_sel   = lslf_pkg::PRD_NXX;
      case (st_ff)
         lslf_pkg::ST_MUL: cmd.mul = 1'b1;
         lslf_pkg::ST_ACC: cmd.acc = 1'b1;
         lslf_pkg::ST_F0:  cmd.prd_start = 1'b1;
         lslf_pkg::ST_PRD_NXX: begin
            cmd.prd_sel   = lslf_pkg::PRD_SXSX;
            cmd.prd_start = stat.prd_done;
         end
         lslf_pkg::ST_PRD_SXSX: begin
            cmd.prd_sel   = lslf_pkg::PRD_P;
            cmd.prd_start = stat.prd_done;
         end
         lslf_pkg::ST_PRD_P: begin
            cmd.prd_sel   = lslf_pkg::PRD_Q;
            cmd.prd_start = stat.prd_done;
         end
         lslf_pkg::ST_PRD_Q: begin
            cmd.prd_sel   = lslf_pkg::PRD_A;
            cmd.prd_start = stat.prd_done;
         end
         lslf_pkg::ST_PRD_A: begin
            cmd.prd_sel   = lslf_pkg::PRD_B;
            cmd.prd_start = stat.prd_done;
         end
         lslf_pkg::ST_F2:  cmd.f2 = 1'b1;
         lslf_pkg::ST_F3: begin
            cmd.f3 = 1'b1;
            cmd.div_start = 1'b1;
         end
         lslf_pkg::ST_DIV_MX: begin
            cmd.div_sel   = lslf_pkg::DIV_MY;
            cmd.div_start = stat.div_done;
         end
         lslf_pkg::ST_DIV_MY: begin
            cmd.div_sel   = lslf_pkg::DIV_SL;
            cmd.div_start = stat.div_done && !stat.degen;
         end
         lslf_pkg::ST_DIV_SL: begin
            cmd.div_sel   = lslf_pkg::DIV_IC;
            cmd.div_start = stat.div_done;
         end
         lslf_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            strobe   = 1'b1;
         end
         default: cmd.div_start = div_idle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= lslf_pkg::ST_IDLE;
      else st_ff <= st_in;
   end
endmodule

// ----- tb/tb_least_squares_line_fit.sv -----
`timescale 1ns / 1ps
module tb_least_squares_line_fit;

   typedef struct {
      bit                is_gain;
      logic [23:0]       gain;
      lslf_pkg::req_type req;
   } stim_type;

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   lslf_pkg::req_type req_payload = '0;
   logic              rsp_strobe;
   lslf_pkg::rsp_type rsp_payload;
   logic              csr_valid = 0;
   logic              csr_ready;
   logic [23:0]       csr_data = '0;

   stim_type          pending[$];
   lslf_pkg::rsp_type fits_due[$];
   int        errors = 0;
   bit        stim_done = 0;

   bit [23:0]  gain_m;
   bit [63:0]  cnt_m, sx_m, sxx_m, sy_m, sxy_m;

   least_squares_line_fit uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_payload(req_payload), .rsp_strobe(rsp_strobe), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] round_sat(bit [159:0] mag, bit neg, bit [159:0] d);
      bit [159:0] q;
      q = (mag * 160'd2 + d) / (d * 160'd2);
      if (!neg) return (q > 160'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      return (q > 160'h8000_0000) ? 32'h8000_0000 : -q[31:0];
   endfunction

   task automatic accumulate_sample(lslf_pkg::req_type r);
      bit [63:0]  x, n, p, q, my, mf;
      bit [159:0] nxx, sxsx, a, b;
      lslf_pkg::rsp_type f;
      if (cnt_m < 64'd256) begin
         x = ({48'b0, r.coil_current} * {40'b0, gain_m}) >> 12;
         cnt_m += 64'd1;
         sx_m += x;
         sxx_m += x * x;
         sy_m += {48'b0, r.hall_voltage};
         sxy_m += x * {48'b0, r.hall_voltage};
      end
      if (!r.last_sample) return;
      n = (cnt_m == 64'd0) ? 64'd1 : cnt_m;
      mf = (sx_m + n * 64'd128) / (n * 64'd256);
      f.mean_field = mf[31:0];
      my = (sy_m * 64'd512 + n) / (64'd2 * n);
      f.mean_voltage = my[31:0];
      nxx = 160'(n) * 160'(sxx_m);
      sxsx = 160'(sx_m) * 160'(sx_m);
      if (nxx <= sxsx) begin
         f.degenerate = 1'b1;
         f.slope = 32'sd0;
         f.intercept = my[31:0];
      end else begin
         f.degenerate = 1'b0;
         p = n * sxy_m;
         q = sx_m * sy_m;
         f.slope = round_sat(160'(p < q ? q - p : p - q) << 32, p < q, nxx - sxsx);
         a = 160'(sxx_m) * 160'(sy_m);
         b = 160'(sx_m) * 160'(sxy_m);
         f.intercept = round_sat((a < b ? b - a : a - b) << 8, a < b, nxx - sxsx);
      end
      fits_due.push_back(f);
      cnt_m = 0; sx_m = 0; sxx_m = 0; sy_m = 0; sxy_m = 0;
   endtask

   task automatic add_sample(int cur, int volt, bit last);
      stim_type s;
      s.is_gain = 0;
      s.gain = '0;
      s.req.coil_current = 16'(cur);
      s.req.hall_voltage = 16'(volt);
      s.req.last_sample = last;
      pending.push_back(s);
   endtask

   task automatic add_gain(logic [23:0] g);
      stim_type s;
      s.is_gain = 1;
      s.gain = g;
      s.req = '0;
      pending.push_back(s);
   endtask

   task automatic add_data_set(int len);
      for (int i = 0; i < len; i++)
         add_sample($urandom_range(0, 65535), $urandom_range(0, 65535), i == len - 1);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // driver
   int  gap = 0;
   int  quiet = 0;
   always @(posedge clock) begin
      bit       nstart, nvalid, free;
      int       nquiet;
      stim_type s;
      if (reset) begin
         start <= 0;
         csr_valid <= 0;
         gain_m = lslf_pkg::FieldGainReset;
         cnt_m = 0; sx_m = 0; sxx_m = 0; sy_m = 0; sxy_m = 0;
         quiet <= 0;
      end else begin
         nstart = start;
         nvalid = csr_valid;
         free = 1;
         nquiet = (!busy && !start && !csr_valid) ? quiet + 1 : 0;
         if (csr_valid && csr_ready) begin
            gain_m = csr_data;
            nvalid = 0;
            nquiet = 0;
         end else if (csr_valid) free = 0;
         if (start && !busy) begin
            accumulate_sample(req_payload);
            nstart = 0;
            if (pending.size() > 40 && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
         end else if (start) free = 0;
         if (free && gap > 0) gap--;
         else if (free && pending.size() > 0) begin
            s = pending[0];
            if (!s.is_gain) begin
               req_payload <= s.req;
               nstart = 1;
               void'(pending.pop_front());
            end else if (quiet >= 8 && fits_due.size() == 0 && !busy && !nstart && !nvalid)
            begin
               csr_data <= s.gain;
               nvalid = 1;
               void'(pending.pop_front());
            end
         end
         start <= nstart;
         csr_valid <= nvalid;
         quiet <= nquiet;
         stim_done <= (pending.size() == 0 && !nstart && !nvalid);
      end
   end

   // monitor
   always @(posedge clock) begin
      lslf_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (fits_due.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            errors++;
         end else begin
            want = fits_due.pop_front();
            if (rsp_payload.slope !== want.slope)
               report_mismatch("slope", rsp_payload.slope, want.slope);
            if (rsp_payload.intercept !== want.intercept)
               report_mismatch("intercept", rsp_payload.intercept, want.intercept);
            if (rsp_payload.mean_field !== want.mean_field)
               report_mismatch("mean_field", rsp_payload.mean_field, want.mean_field);
            if (rsp_payload.mean_voltage !== want.mean_voltage)
               report_mismatch("mean_voltage", rsp_payload.mean_voltage, want.mean_voltage);
            if (rsp_payload.degenerate !== want.degenerate)
               report_mismatch("degenerate", 32'(rsp_payload.degenerate),
                               32'(want.degenerate));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int len;
      add_sample(65535, 65535, 0);
      add_sample(0, 0, 1);
      add_sample(4096, 256, 1);
      add_sample(1000, 500, 0);
      add_sample(1000, 9000, 1);
      add_sample(0, 65535, 0);
      add_sample(65535, 0, 0);
      add_sample(32768, 32768, 1);
      add_gain(24'hFFFFFF);
      add_sample(65535, 0, 0);
      add_sample(0, 65535, 1);
      add_sample(65535, 65535, 0);
      add_sample(65534, 1, 0);
      add_sample(1, 65534, 1);
      add_gain(24'd0);
      add_sample(12345, 100, 0);
      add_sample(54321, 200, 1);
      add_gain(lslf_pkg::FieldGainReset);
      for (int i = 0; i < 262; i++)
         add_sample($urandom_range(0, 65535), $urandom_range(0, 65535), i == 261);
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: add_gain(24'd1);
            1: add_gain(24'hFFFFFF);
            default: add_gain(24'($urandom_range(0, 24'hFFFFFF)));
         endcase
         for (int k = 0; k < 8; k++) begin
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 7);
            add_data_set(len);
         end
         if (ph == 2)
            for (int k = 0; k < 6; k++)
               add_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                          1'($urandom_range(0, 1)));
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      @(posedge clock);
      while (!(stim_done && fits_due.size() == 0)) @(posedge clock);
      repeat (700) @(posedge clock);
      if (errors == 0 && fits_due.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/lslf_pkg.sv
hw/rtl/lslf_div.sv
hw/rtl/lslf_datapath.sv
hw/rtl/lslf_ctrl.sv
hw/rtl/least_squares_line_fit.sv
tb/tb_least_squares_line_fit.sv
